// File: src/qrs_pkg.sv
package qrs_pkg;

  // Width of each root field, signed fixed point
  localparam int unsigned ROOT_WIDTH = 34;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_e;

  // Control that travels with every request through the cells
  typedef struct packed {
    logic    valid;
    status_e status;
  } step_t;

endpackage

// File: src/qrs_sqrt_cell.sv
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int unsigned SW = 33,
  parameter int unsigned NW = 66,
  parameter int unsigned TW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  step_t         ctl_i,
  input  logic [NW-1:0] n_i,
  input  logic [SW+1:0] r_i,
  input  logic [SW-1:0] q_i,
  input  logic [TW-1:0] tag_i,
  output step_t         ctl_o,
  output logic [NW-1:0] n_o,
  output logic [SW+1:0] r_o,
  output logic [SW-1:0] q_o,
  output logic [TW-1:0] tag_o
);

  logic [SW+1:0] r2, trial;
  logic          ge;
  step_t         ctl_q;
  logic [NW-1:0] n_q;
  logic [SW+1:0] r_q;
  logic [SW-1:0] q_q;
  logic [TW-1:0] tag_q;

  // Bring down two radicand bits and try the next root digit
  assign r2    = {r_i[SW-1:0], n_i[NW-1:NW-2]};
  assign trial = {q_i, 2'b01};
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Advance the partial root and remainder
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n_q   <= {n_i[NW-3:0], 2'b00};
      r_q   <= ge ? (r2 - trial) : r2;
      q_q   <= {q_i[SW-2:0], ge};
      tag_q <= tag_i;
    end
  end

  assign ctl_o = ctl_q;
  assign n_o   = n_q;
  assign r_o   = r_q;
  assign q_o   = q_q;
  assign tag_o = tag_q;

endmodule

// File: src/qrs_div_cell.sv
module qrs_div_cell import qrs_pkg::*; #(
  parameter int unsigned NUMW = 34,
  parameter int unsigned DVW  = 17,
  parameter int unsigned TW   = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  step_t           ctl_i,
  input  logic [DVW-1:0]  d_i,
  input  logic [NUMW-1:0] np_i,
  input  logic [DVW-1:0]  rp_i,
  input  logic [NUMW-1:0] nm_i,
  input  logic [DVW-1:0]  rm_i,
  input  logic [TW-1:0]   tag_i,
  output step_t           ctl_o,
  output logic [DVW-1:0]  d_o,
  output logic [NUMW-1:0] np_o,
  output logic [DVW-1:0]  rp_o,
  output logic [NUMW-1:0] nm_o,
  output logic [DVW-1:0]  rm_o,
  output logic [TW-1:0]   tag_o
);

  logic [DVW:0]    p2, m2;
  logic            pge, mge;
  step_t           ctl_q;
  logic [DVW-1:0]  d_q, rp_q, rm_q;
  logic [NUMW-1:0] np_q, nm_q;
  logic [TW-1:0]   tag_q;

  // Shift one dividend bit into each remainder and compare
  assign p2  = {rp_i, np_i[NUMW-1]};
  assign m2  = {rm_i, nm_i[NUMW-1]};
  assign pge = (p2 >= {1'b0, d_i});
  assign mge = (m2 >= {1'b0, d_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Shift quotient bits in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q   <= d_i;
      rp_q  <= pge ? DVW'(p2 - {1'b0, d_i}) : DVW'(p2);
      rm_q  <= mge ? DVW'(m2 - {1'b0, d_i}) : DVW'(m2);
      np_q  <= {np_i[NUMW-2:0], pge};
      nm_q  <= {nm_i[NUMW-2:0], mge};
      tag_q <= tag_i;
    end
  end

  assign ctl_o = ctl_q;
  assign d_o   = d_q;
  assign rp_o  = rp_q;
  assign rm_o  = rm_q;
  assign np_o  = np_q;
  assign nm_o  = nm_q;
  assign tag_o = tag_q;

endmodule

// File: src/quadratic_root_solver.sv
// A request passes stage 1, stage 2, the square-root row, stage 3, the divider row and the output stage.
// Throughput: one request per cycle; a row of square-root cells (one root bit each)
// feeds a row of divider cells (one quotient bit each), all advancing together.
// The whole row holds while a result waits at the output and the sink is not ready.
// Reset (rst_ni low, asynchronous) clears every valid flag; data registers are not reset.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // coef_a, coef_b, coef_c from bit 0 up, zero fill to bytes
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // root_plus, root_minus from bit 0 up, zero fill to bytes
  output logic [((2*ROOT_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // root_status
  output logic [1:0] m_axis_tuser_o
);

  localparam int unsigned CW   = COEF_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DW   = 2*CW + 1;
  localparam int unsigned SW   = CW + F + 1;
  localparam int unsigned NW   = 2*SW;
  localparam int unsigned NSW  = CW + F + 3;
  localparam int unsigned NUMW = NSW - 1;
  localparam int unsigned DVW  = CW + 1;
  localparam int unsigned QW   = NUMW + 1;
  localparam int unsigned RW   = ROOT_WIDTH;
  localparam int unsigned XW   = (QW > RW) ? QW : RW;
  localparam int unsigned ODW  = ((2*ROOT_WIDTH+7)/8)*8;
  localparam logic signed [XW-1:0] HI = {{(XW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic signed [XW-1:0] LO = ~HI;

  logic adv;
  logic out_valid_q;

  // Hold the whole row while a result waits
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Stage 1: magnitudes and products
  logic signed [CW-1:0] a_in, b_in, c_in;
  logic [CW-1:0]        ma_in, mb_in, mc_in;
  logic                 v1_q, acpos_q, azero_q;
  logic [2*CW-1:0]      bb_q, ac_q;
  logic signed [CW-1:0] a1_q, b1_q;

  assign a_in  = s_axis_tdata_i[CW-1:0];
  assign b_in  = s_axis_tdata_i[2*CW-1:CW];
  assign c_in  = s_axis_tdata_i[3*CW-1:2*CW];
  assign ma_in = a_in[CW-1] ? (~a_in + 1'b1) : a_in;
  assign mb_in = b_in[CW-1] ? (~b_in + 1'b1) : b_in;
  assign mc_in = c_in[CW-1] ? (~c_in + 1'b1) : c_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q    <= mb_in * mb_in;
      ac_q    <= ma_in * mc_in;
      acpos_q <= (a_in[CW-1] == c_in[CW-1]) && (c_in != '0);
      azero_q <= (a_in == '0);
      a1_q    <= a_in;
      b1_q    <= b_in;
    end
  end

  // Stage 2: discriminant and classification
  logic [DW+1:0]        bb_ext, ac4, dif, sum;
  logic [DW-1:0]        disc_d, disc_q;
  status_e              st_d;
  step_t                ctl2_q;
  logic signed [CW-1:0] a2_q, b2_q;

  assign bb_ext = {3'b000, bb_q};
  assign ac4    = {1'b0, ac_q, 2'b00};
  assign dif    = bb_ext - ac4;
  assign sum    = bb_ext + ac4;
  assign disc_d = acpos_q ? dif[DW-1:0] : sum[DW-1:0];

  always_comb begin
    if (azero_q) begin
      st_d = ST_AZERO;
    end else if (acpos_q && dif[DW+1]) begin
      st_d = ST_NONE;
    end else if (disc_d == '0) begin
      st_d = ST_ONE;
    end else begin
      st_d = ST_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (adv) begin
      ctl2_q <= '{valid: v1_q, status: st_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      disc_q <= disc_d;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
    end
  end

  // Square-root row: one root bit per cell
  step_t           sctl [SW+1];
  logic [NW-1:0]   sn   [SW+1];
  logic [SW+1:0]   sr   [SW+1];
  logic [SW-1:0]   sq   [SW+1];
  logic [2*CW-1:0] stag [SW+1];

  assign sctl[0] = ctl2_q;
  assign sn[0]   = NW'(disc_q) << (2*F);
  assign sr[0]   = '0;
  assign sq[0]   = '0;
  assign stag[0] = {a2_q, b2_q};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .NW(NW), .TW(2*CW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (sctl[i]),
      .n_i   (sn[i]),
      .r_i   (sr[i]),
      .q_i   (sq[i]),
      .tag_i (stag[i]),
      .ctl_o (sctl[i+1]),
      .n_o   (sn[i+1]),
      .r_o   (sr[i+1]),
      .q_o   (sq[i+1]),
      .tag_o (stag[i+1])
    );
  end

  // Stage 3: signed numerators, magnitudes and quotient signs
  logic signed [CW-1:0]  a3, b3;
  logic [CW-1:0]         ma3;
  logic signed [NSW-1:0] bx, nump, numm;
  logic [NSW-1:0]        mp, mm;
  step_t                 ctl4_q;
  logic [NUMW-1:0]       np4_q, nm4_q;
  logic [DVW-1:0]        d4_q;
  logic [1:0]            neg4_q;

  assign a3   = stag[SW][2*CW-1:CW];
  assign b3   = stag[SW][CW-1:0];
  assign ma3  = a3[CW-1] ? (~a3 + 1'b1) : a3;
  assign bx   = NSW'(b3) <<< F;
  assign nump = NSW'(sq[SW]) - bx;
  assign numm = -bx - NSW'(sq[SW]);
  assign mp   = nump[NSW-1] ? -nump : nump;
  assign mm   = numm[NSW-1] ? -numm : numm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (adv) begin
      ctl4_q <= sctl[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      np4_q  <= mp[NUMW-1:0];
      nm4_q  <= mm[NUMW-1:0];
      d4_q   <= {ma3, 1'b0};
      neg4_q <= {nump[NSW-1] ^ a3[CW-1], numm[NSW-1] ^ a3[CW-1]};
    end
  end

  // Divider row: one quotient bit per cell for both roots
  step_t           dctl [NUMW+1];
  logic [DVW-1:0]  dd   [NUMW+1];
  logic [NUMW-1:0] dnp  [NUMW+1];
  logic [DVW-1:0]  drp  [NUMW+1];
  logic [NUMW-1:0] dnm  [NUMW+1];
  logic [DVW-1:0]  drm  [NUMW+1];
  logic [1:0]      dtag [NUMW+1];

  assign dctl[0] = ctl4_q;
  assign dd[0]   = d4_q;
  assign dnp[0]  = np4_q;
  assign drp[0]  = '0;
  assign dnm[0]  = nm4_q;
  assign drm[0]  = '0;
  assign dtag[0] = neg4_q;

  for (genvar j = 0; j < NUMW; j++) begin : g_div
    qrs_div_cell #(.NUMW(NUMW), .DVW(DVW), .TW(2)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (dctl[j]),
      .d_i   (dd[j]),
      .np_i  (dnp[j]),
      .rp_i  (drp[j]),
      .nm_i  (dnm[j]),
      .rm_i  (drm[j]),
      .tag_i (dtag[j]),
      .ctl_o (dctl[j+1]),
      .d_o   (dd[j+1]),
      .np_o  (dnp[j+1]),
      .rp_o  (drp[j+1]),
      .nm_o  (dnm[j+1]),
      .rm_o  (drm[j+1]),
      .tag_o (dtag[j+1])
    );
  end

  // Output stage: sign, saturate, drop roots that do not exist
  logic signed [QW-1:0] sp, sm;
  logic signed [XW-1:0] xp, xm, cp, cm;
  logic                 absent;
  status_e              status_q;
  logic [RW-1:0]        rp_q, rm_q;

  assign sp     = dtag[NUMW][1] ? -$signed({1'b0, dnp[NUMW]}) : $signed({1'b0, dnp[NUMW]});
  assign sm     = dtag[NUMW][0] ? -$signed({1'b0, dnm[NUMW]}) : $signed({1'b0, dnm[NUMW]});
  assign xp     = XW'(sp);
  assign xm     = XW'(sm);
  assign cp     = (xp > HI) ? HI : ((xp < LO) ? LO : xp);
  assign cm     = (xm > HI) ? HI : ((xm < LO) ? LO : xm);
  assign absent = (dctl[NUMW].status == ST_NONE) || (dctl[NUMW].status == ST_AZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dctl[NUMW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= dctl[NUMW].status;
      rp_q     <= absent ? '0 : cp[RW-1:0];
      rm_q     <= absent ? '0 : cm[RW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = ODW'({rm_q, rp_q});

  // Absent roots read as zero
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_NONE || m_axis_tuser_o == ST_AZERO)
      |-> m_axis_tdata_o == '0)
    else $error("absent root not zero");

  // A repeated root shows the same value twice
  a_one_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_ONE) |-> rp_q == rm_q)
    else $error("repeated root differs");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a waiting result");

endmodule
